// ===== rtl/core/cqe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue engine package
// Shared widths, request and status codes, control bundles and index helpers.
// ----------------------------------------------------------------------------
package cqe_pkg;

    // Built depth of the slot store, from 2 to 64.
    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int QLEN_W = 7;

    localparam logic [QLEN_W-1:0] QLEN_RESET = QLEN_W'(64);

    localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    // One access of the slot store.
    typedef struct packed {
        logic             en;
        logic             we;
        logic [IDX_W-1:0] addr;
    } mem_cmd_t;

    // Request to load the output stage with a result.
    typedef struct packed {
        logic    load;
        status_t status;
        logic    last;
        logic    from_ram;
    } rsp_load_t;

    // Controller status seen by the top level.
    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] occupancy;
    } ctrl_stat_t;

    // Length in use: zero acts as one, anything above the depth as the depth.
    function automatic logic [CNT_W-1:0] eff_len(input logic [QLEN_W-1:0] qlen);
        logic [CNT_W-1:0] len;
        if (qlen == '0)
            len = CNT_W'(1);
        else if (qlen > QLEN_W'(DEPTH))
            len = CNT_W'(DEPTH);
        else
            len = CNT_W'(qlen);
        return len;
    endfunction

    // Step an index by one, wrapping to zero at the length in use.
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(idx) + CNT_W'(1);
        if (nxt >= len)
            return '0;
        return nxt[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/core/cqe_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one queue request per transfer.
// ----------------------------------------------------------------------------
interface cqe_req_if;
    logic                                valid;
    logic                                ready;
    logic        [cqe_pkg::REQ_W-1:0]    req_type;
    logic signed [cqe_pkg::DATA_W-1:0]   push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

// ===== rtl/core/cqe_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one queue result per transfer.
// ----------------------------------------------------------------------------
interface cqe_rsp_if;
    logic                                valid;
    logic                                ready;
    logic        [cqe_pkg::STAT_W-1:0]   status;
    logic signed [cqe_pkg::DATA_W-1:0]   data_out;
    logic                                last;

    modport source (output valid, output status, output data_out, output last, input ready);
    modport sink   (input valid, input status, input data_out, input last, output ready);
endinterface

// ===== rtl/core/cqe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered and held between reads.
// ----------------------------------------------------------------------------
module cqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
            mem[addr] <= wdata;
        if (en && !we)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/cqe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue engine controller
// Keeps the head, tail, occupancy and length, and sequences store accesses.
// ----------------------------------------------------------------------------
module cqe_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cqe_pkg::QLEN_W-1:0]   cfg_wdata,
    input  logic                         req_valid,
    input  logic [cqe_pkg::REQ_W-1:0]    req_type,
    input  logic                         out_free,
    output logic                         req_ready,
    output cqe_pkg::mem_cmd_t            mem_cmd,
    output cqe_pkg::rsp_load_t           rsp_load,
    output cqe_pkg::ctrl_stat_t          stat
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DATA = 2'b10
    } state_t;

    state_t                        state_reg,  state_next;
    logic [cqe_pkg::IDX_W-1:0]     head_reg,   head_next;
    logic [cqe_pkg::IDX_W-1:0]     tail_reg,   tail_next;
    logic [cqe_pkg::IDX_W-1:0]     walk_reg,   walk_next;
    logic [cqe_pkg::CNT_W-1:0]     occ_reg,    occ_next;
    logic [cqe_pkg::CNT_W-1:0]     remain_reg, remain_next;
    logic [cqe_pkg::QLEN_W-1:0]    qlen_reg;
    logic [cqe_pkg::CNT_W-1:0]     len;
    logic                          accept;

    assign len       = cqe_pkg::eff_len(qlen_reg);
    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign stat      = '{idle: (state_reg == ST_IDLE), occupancy: occ_reg};

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        walk_next   = walk_reg;
        occ_next    = occ_reg;
        remain_next = remain_reg;
        mem_cmd     = '{en: 1'b0, we: 1'b0, addr: '0};
        rsp_load    = '{load: 1'b0, status: cqe_pkg::STAT_OK, last: 1'b1, from_ram: 1'b0};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        cqe_pkg::REQ_ENQ:
                        begin
                            rsp_load.load = 1'b1;
                            if (occ_reg >= len)
                            begin
                                rsp_load.status = cqe_pkg::STAT_OVERFLOW;
                            end
                            else
                            begin
                                mem_cmd   = '{en: 1'b1, we: 1'b1, addr: tail_reg};
                                tail_next = cqe_pkg::advance(tail_reg, len);
                                occ_next  = occ_reg + cqe_pkg::CNT_W'(1);
                            end
                        end
                        cqe_pkg::REQ_DEQ:
                        begin
                            if (occ_reg == '0)
                            begin
                                rsp_load.load   = 1'b1;
                                rsp_load.status = cqe_pkg::STAT_UNDERFLOW;
                            end
                            else
                            begin
                                mem_cmd     = '{en: 1'b1, we: 1'b0, addr: head_reg};
                                occ_next    = occ_reg - cqe_pkg::CNT_W'(1);
                                remain_next = cqe_pkg::CNT_W'(1);
                                state_next  = ST_DATA;
                                // Emptying the queue brings both indexes back to slot zero.
                                if (occ_reg == cqe_pkg::CNT_W'(1))
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                                else
                                begin
                                    head_next = cqe_pkg::advance(head_reg, len);
                                end
                            end
                        end
                        cqe_pkg::REQ_DUMP:
                        begin
                            if (occ_reg == '0)
                            begin
                                rsp_load.load   = 1'b1;
                                rsp_load.status = cqe_pkg::STAT_UNDERFLOW;
                            end
                            else
                            begin
                                mem_cmd     = '{en: 1'b1, we: 1'b0, addr: head_reg};
                                walk_next   = cqe_pkg::advance(head_reg, len);
                                remain_next = occ_reg;
                                state_next  = ST_DATA;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DATA:
            begin
                // Read data is held by the store until the next read is issued.
                if (out_free)
                begin
                    rsp_load.load     = 1'b1;
                    rsp_load.from_ram = 1'b1;
                    rsp_load.last     = (remain_reg == cqe_pkg::CNT_W'(1));
                    remain_next       = remain_reg - cqe_pkg::CNT_W'(1);
                    if (remain_reg == cqe_pkg::CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_cmd   = '{en: 1'b1, we: 1'b0, addr: walk_reg};
                        walk_next = cqe_pkg::advance(walk_reg, len);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            walk_reg   <= '0;
            occ_reg    <= '0;
            remain_reg <= '0;
            qlen_reg   <= cqe_pkg::QLEN_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            walk_reg   <= walk_next;
            occ_reg    <= occ_next;
            remain_reg <= remain_next;
            if (cfg_we)
                qlen_reg <= cfg_wdata;
        end
    end

endmodule

// ===== rtl/core/circular_queue_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue engine
// FIFO of signed 32-bit values held in a single-port RAM, with enqueue,
// dequeue and in-order dump requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req channel (req_type, push_value) and results
//   leave on the rsp channel (status, data_out, last); a transfer happens on
//   a rising edge with valid and ready both high. Every request gives one
//   result, except a dump of a non-empty queue, which gives one result per
//   stored value, oldest first, with last set on the final one. Request code
//   three is dropped without a result.
//   Enqueue, overflow and underflow results appear in the cycle after the
//   request transfer. A dequeue or a dump first reads the slot store into
//   its read register and loads the output register from there; a dump
//   then streams one value per cycle while the receiver keeps taking them.
//   An enqueue, an overflow or an underflow leaves the controller idle, while
//   a dequeue or dump holds off new requests until its last value is loaded.
//   The queue length register is written through cfg_we/cfg_wdata; the user
//   must write it only while the block is idle, which the block does not
//   enforce. Reset empties the queue and sets the length to 64; the slot
//   store itself is not cleared and needs no clearing pass. When the
//   receiver stalls the result stays in the output register and both the
//   store walk and request acceptance pause until it is taken.
// ----------------------------------------------------------------------------
module circular_queue_engine_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cqe_pkg::QLEN_W-1:0]   cfg_wdata,
    cqe_req_if.sink                      req,
    cqe_rsp_if.source                    rsp
);

    cqe_pkg::mem_cmd_t                 mem_cmd;
    cqe_pkg::rsp_load_t                rsp_load;
    cqe_pkg::ctrl_stat_t               stat;
    logic [cqe_pkg::DATA_W-1:0]        ram_rdata;
    logic                              out_free;

    // Output stage: one registered result waiting for its transfer.
    logic                              out_valid_reg;
    cqe_pkg::status_t                  out_status_reg;
    logic [cqe_pkg::DATA_W-1:0]        out_data_reg;
    logic                              out_last_reg;

    // The output register may be refilled in the same cycle as it is emptied.
    assign out_free = !out_valid_reg || rsp.ready;

    cqe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .out_free  (out_free),
        .req_ready (req.ready),
        .mem_cmd   (mem_cmd),
        .rsp_load  (rsp_load),
        .stat      (stat)
    );

    // The slot store: enqueues write it, dequeues and dumps read it.
    cqe_ram #(
        .WIDTH (cqe_pkg::DATA_W),
        .DEPTH (cqe_pkg::DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .en    (mem_cmd.en),
        .we    (mem_cmd.we),
        .addr  (mem_cmd.addr),
        .wdata (req.push_value),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_load.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        if (rsp_load.load)
        begin
            out_status_reg <= rsp_load.status;
            out_data_reg   <= rsp_load.from_ram ? ram_rdata : '0;
            out_last_reg   <= rsp_load.last;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.data_out = out_data_reg;
    assign rsp.last     = out_last_reg;

    // The occupancy never exceeds the built depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.occupancy <= cqe_pkg::CNT_W'(cqe_pkg::DEPTH))
        else $error("occupancy above built depth");

    // A new result is never loaded over one that has not been transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load.load |-> out_free)
        else $error("result overwritten before transfer");

    // A dequeue or dump of a non-empty queue keeps the controller busy for its read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && stat.occupancy != '0 &&
         (req.req_type == cqe_pkg::REQ_DEQ || req.req_type == cqe_pkg::REQ_DUMP))
        |=> !stat.idle && !req.ready)
        else $error("store read not followed by busy controller");

    // A store read is only issued while the output stage can take its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_cmd.en && !mem_cmd.we) |-> out_free)
        else $error("store read issued with output stage blocked");

endmodule
